@@ src/ifmr_pkg.sv @@
// ----------------------------------------------------------------------------
// ifmr_pkg
// Shared types and constants for the rounded floating-point multiplier.
// ----------------------------------------------------------------------------
package ifmr_pkg;

    // operand and result categories
    typedef enum logic [1:0] {
        CAT_ZERO   = 2'd0,
        CAT_NORMAL = 2'd1,
        CAT_INF    = 2'd2,
        CAT_NAN    = 2'd3
    } category_t;

    // format codes
    localparam logic [1:0] FMT_HALF   = 2'd0;
    localparam logic [1:0] FMT_SINGLE = 2'd1;
    localparam logic [1:0] FMT_DOUBLE = 2'd2;

    // rounding mode codes
    localparam logic [2:0] RND_ZERO         = 3'd0;
    localparam logic [2:0] RND_NEAREST_EVEN = 3'd1;
    localparam logic [2:0] RND_NEAREST_AWAY = 3'd2;
    localparam logic [2:0] RND_UP           = 3'd3;
    localparam logic [2:0] RND_DOWN         = 3'd4;

    // register indexes
    localparam logic REG_FORMAT        = 1'b0;
    localparam logic REG_ROUNDING_MODE = 1'b1;

    localparam int MANT_W = 53;
    localparam int EXP_W  = 11;
    localparam int PEXP_W = 13;
    localparam int PROD_W = 2 * MANT_W;
    localparam int LO_W   = 27;
    localparam int HI_W   = MANT_W - LO_W;
    localparam int MSB_W  = 7;

    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 72;

    // mantissa width of a format
    function automatic logic [5:0] fmt_mant_bits(input logic [1:0] fmt);
        case (fmt)
            FMT_HALF:   fmt_mant_bits = 6'd11;
            FMT_SINGLE: fmt_mant_bits = 6'd24;
            default:    fmt_mant_bits = 6'd53;
        endcase
    endfunction

    // largest normal exponent of a format
    function automatic logic signed [13:0] fmt_emax(input logic [1:0] fmt);
        case (fmt)
            FMT_HALF:   fmt_emax = 14'sd15;
            FMT_SINGLE: fmt_emax = 14'sd127;
            default:    fmt_emax = 14'sd1023;
        endcase
    endfunction

endpackage

@@ src/ieee_float_multiply_rounded.sv @@
// ----------------------------------------------------------------------------
// ieee_float_multiply_rounded
// Six-stage pipelined multiplier for unpacked half, single or double values
// with five rounding modes and an out-of-range exponent flag.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// s_        in         s_tvalid / s_tready    operand pair (s_tdata)
// m_        out        m_tvalid / m_tready    rounded product (m_tdata)
// apb       in         psel/penable/pready    format, rounding_mode
//
// one pair is taken every cycle while no stage is stalled; each pair
// passes the six register stages in turn (operand capture, partial
// products, product sum, leading-one search, normalize, round).
// each stage holds on its own while the one after it is full and stalled,
// so bubbles are squeezed out and nothing is lost or repeated.
// reset sets format to single and rounding to nearest ties even.
// ----------------------------------------------------------------------------
module ieee_float_multiply_rounded (
    input  logic                          aclk,
    input  logic                          aresetn,
    // a_category, a_negative, a_exponent, a_mantissa, b_category,
    // b_negative, b_exponent, b_mantissa, zero pad
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ifmr_pkg::S_DATA_W-1:0] s_tdata,
    // product_category, product_negative, product_exponent,
    // product_mantissa, exponent_out_of_range, zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ifmr_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ifmr_pkg::*;

    // configuration registers
    logic [1:0] format_reg;
    logic [2:0] rmode_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FMT_SINGLE;
            rmode_reg  <= RND_NEAREST_EVEN;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_FORMAT:        format_reg <= pwdata[1:0];
                REG_ROUNDING_MODE: rmode_reg  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FORMAT: prdata = {30'd0, format_reg};
            default:    prdata = {29'd0, rmode_reg};
        endcase
    end

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic r1, r2, r3, r4, r5, r6;

    assign r6 = !v6_reg || m_tready;
    assign r5 = !v5_reg || r6;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign s_tready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= s_tvalid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
        end
    end

    // input unpacking
    logic [1:0]        a_cat, b_cat;
    logic              a_neg, b_neg;
    logic [EXP_W-1:0]  a_exp, b_exp;
    logic [MANT_W-1:0] a_man, b_man;
    assign a_cat = s_tdata[1:0];
    assign a_neg = s_tdata[2];
    assign a_exp = s_tdata[13:3];
    assign a_man = s_tdata[66:14];
    assign b_cat = s_tdata[68:67];
    assign b_neg = s_tdata[69];
    assign b_exp = s_tdata[80:70];
    assign b_man = s_tdata[133:81];

    // stage 1: specials, sign, exponent sum, masked mantissas
    logic [1:0]        fmt_c;
    logic [MANT_W-1:0] mmask;
    logic [1:0]        cat_c;
    logic              neg_c;
    logic [1:0]        fmt1_reg;
    logic [2:0]        rm1_reg;
    logic [1:0]        cat1_reg;
    logic              neg1_reg;
    logic signed [11:0] esum1_reg;
    logic [MANT_W-1:0] am1_reg, bm1_reg;

    always_comb begin
        fmt_c = (format_reg == FMT_HALF || format_reg == FMT_SINGLE) ?
                format_reg : FMT_DOUBLE;
        mmask = (MANT_W'(1) << fmt_mant_bits(fmt_c)) - MANT_W'(1);
        if (b_cat == CAT_NAN)      neg_c = b_neg;
        else if (a_cat == CAT_NAN) neg_c = a_neg;
        else                       neg_c = a_neg ^ b_neg;
        if (a_cat == CAT_NAN || b_cat == CAT_NAN)
            cat_c = CAT_NAN;
        else if ((a_cat == CAT_INF || b_cat == CAT_INF) &&
                 (a_cat == CAT_ZERO || b_cat == CAT_ZERO))
            cat_c = CAT_NAN;
        else if (a_cat == CAT_INF || b_cat == CAT_INF)
            cat_c = CAT_INF;
        else if (a_cat == CAT_ZERO || b_cat == CAT_ZERO)
            cat_c = CAT_ZERO;
        else
            cat_c = CAT_NORMAL;
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            fmt1_reg  <= fmt_c;
            rm1_reg   <= rmode_reg;
            cat1_reg  <= cat_c;
            neg1_reg  <= neg_c;
            esum1_reg <= $signed({a_exp[EXP_W-1], a_exp}) +
                         $signed({b_exp[EXP_W-1], b_exp});
            am1_reg   <= a_man & mmask;
            bm1_reg   <= b_man & mmask;
        end
    end

    // stage 2: partial products
    logic [1:0]        fmt2_reg;
    logic [2:0]        rm2_reg;
    logic [1:0]        cat2_reg;
    logic              neg2_reg;
    logic signed [11:0] esum2_reg;
    logic [2*LO_W-1:0]      p00_reg;
    logic [LO_W+HI_W-1:0]   p01_reg, p10_reg;
    logic [2*HI_W-1:0]      p11_reg;

    always_ff @(posedge aclk) begin
        if (r2) begin
            fmt2_reg  <= fmt1_reg;
            rm2_reg   <= rm1_reg;
            cat2_reg  <= cat1_reg;
            neg2_reg  <= neg1_reg;
            esum2_reg <= esum1_reg;
            p00_reg   <= am1_reg[LO_W-1:0] * bm1_reg[LO_W-1:0];
            p01_reg   <= am1_reg[LO_W-1:0] * bm1_reg[MANT_W-1:LO_W];
            p10_reg   <= am1_reg[MANT_W-1:LO_W] * bm1_reg[LO_W-1:0];
            p11_reg   <= am1_reg[MANT_W-1:LO_W] * bm1_reg[MANT_W-1:LO_W];
        end
    end

    // stage 3: full product
    logic [1:0]        fmt3_reg;
    logic [2:0]        rm3_reg;
    logic [1:0]        cat3_reg;
    logic              neg3_reg;
    logic signed [11:0] esum3_reg;
    logic [PROD_W-1:0] prod3_reg;

    always_ff @(posedge aclk) begin
        if (r3) begin
            fmt3_reg  <= fmt2_reg;
            rm3_reg   <= rm2_reg;
            cat3_reg  <= cat2_reg;
            neg3_reg  <= neg2_reg;
            esum3_reg <= esum2_reg;
            prod3_reg <= (PROD_W'(p11_reg) << (2 * LO_W)) +
                         ((PROD_W'(p01_reg) + PROD_W'(p10_reg)) << LO_W) +
                         PROD_W'(p00_reg);
        end
    end

    // stage 4: leading-one search
    logic [MSB_W-1:0]  msb_c;
    logic              nz_c;
    logic [1:0]        fmt4_reg;
    logic [2:0]        rm4_reg;
    logic [1:0]        cat4_reg;
    logic              neg4_reg;
    logic signed [11:0] esum4_reg;
    logic [PROD_W-1:0] prod4_reg;
    logic [MSB_W-1:0]  msb4_reg;

    always_comb begin
        msb_c = '0;
        nz_c  = |prod3_reg;
        for (int i = 0; i < PROD_W; i++) begin
            if (prod3_reg[i]) msb_c = MSB_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (r4) begin
            fmt4_reg  <= fmt3_reg;
            rm4_reg   <= rm3_reg;
            cat4_reg  <= (cat3_reg == CAT_NORMAL && !nz_c) ? CAT_ZERO : cat3_reg;
            neg4_reg  <= neg3_reg;
            esum4_reg <= esum3_reg;
            prod4_reg <= prod3_reg;
            msb4_reg  <= msb_c;
        end
    end

    // stage 5: normalize to the top bit, exponent
    logic [1:0]        fmt5_reg;
    logic [2:0]        rm5_reg;
    logic [1:0]        cat5_reg;
    logic              neg5_reg;
    logic signed [13:0] e5_reg;
    logic [PROD_W-1:0] norm5_reg;

    always_ff @(posedge aclk) begin
        if (r5) begin
            fmt5_reg  <= fmt4_reg;
            rm5_reg   <= rm4_reg;
            cat5_reg  <= cat4_reg;
            neg5_reg  <= neg4_reg;
            norm5_reg <= prod4_reg << (MSB_W'(PROD_W - 1) - msb4_reg);
            e5_reg    <= $signed({{2{esum4_reg[11]}}, esum4_reg}) +
                         $signed({7'd0, msb4_reg}) -
                         $signed({7'd0, fmt_mant_bits(fmt4_reg), 1'b0}) +
                         14'sd2;
        end
    end

    // stage 6: round, renormalize, range flag
    logic [MANT_W-1:0] mant_c;
    logic              guard_c, sticky_c, inc_c, carry_c;
    logic [MANT_W:0]   minc_c;
    logic [MANT_W-1:0] mfin_c;
    logic signed [13:0] efin_c;
    logic              flag_c;
    logic [1:0]        cat6_reg;
    logic              neg6_reg;
    logic [PEXP_W-1:0] exp6_reg;
    logic [MANT_W-1:0] mant6_reg;
    logic              flag6_reg;
    logic [1:0]        fmt6_reg;

    always_comb begin
        case (fmt5_reg)
            FMT_HALF: begin
                mant_c   = MANT_W'(norm5_reg[PROD_W-1 -: 11]);
                guard_c  = norm5_reg[PROD_W-12];
                sticky_c = |norm5_reg[PROD_W-13:0];
            end
            FMT_SINGLE: begin
                mant_c   = MANT_W'(norm5_reg[PROD_W-1 -: 24]);
                guard_c  = norm5_reg[PROD_W-25];
                sticky_c = |norm5_reg[PROD_W-26:0];
            end
            default: begin
                mant_c   = norm5_reg[PROD_W-1 -: MANT_W];
                guard_c  = norm5_reg[PROD_W-MANT_W-1];
                sticky_c = |norm5_reg[PROD_W-MANT_W-2:0];
            end
        endcase
        case (rm5_reg)
            RND_NEAREST_EVEN: inc_c = guard_c && (sticky_c || mant_c[0]);
            RND_NEAREST_AWAY: inc_c = guard_c;
            RND_UP:           inc_c = !neg5_reg && (guard_c || sticky_c);
            RND_DOWN:         inc_c = neg5_reg && (guard_c || sticky_c);
            default:          inc_c = 1'b0;
        endcase
        minc_c  = {1'b0, mant_c} + (MANT_W + 1)'(inc_c);
        carry_c = (minc_c >> fmt_mant_bits(fmt5_reg)) != '0;
        mfin_c  = carry_c ? minc_c[MANT_W:1] : minc_c[MANT_W-1:0];
        efin_c  = e5_reg + (carry_c ? 14'sd1 : 14'sd0);
        flag_c  = (efin_c > fmt_emax(fmt5_reg)) ||
                  (efin_c < 14'sd1 - fmt_emax(fmt5_reg));
    end

    always_ff @(posedge aclk) begin
        if (r6) begin
            cat6_reg <= cat5_reg;
            neg6_reg <= neg5_reg;
            fmt6_reg <= fmt5_reg;
            if (cat5_reg == CAT_NORMAL) begin
                exp6_reg  <= efin_c[PEXP_W-1:0];
                mant6_reg <= mfin_c;
                flag6_reg <= flag_c;
            end else begin
                exp6_reg  <= '0;
                mant6_reg <= '0;
                flag6_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = {2'b00, flag6_reg, mant6_reg, exp6_reg, neg6_reg, cat6_reg};

    // non-normal results carry no exponent, mantissa or flag
    a_special_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (v6_reg && cat6_reg != CAT_NORMAL) |->
            (mant6_reg == '0 && exp6_reg == '0 && !flag6_reg))
        else $error("special result with nonzero fields");

    // a normal result has its leading one exactly at the format's top bit
    a_normalized: assert property (@(posedge aclk) disable iff (!aresetn)
        (v6_reg && cat6_reg == CAT_NORMAL) |->
            ((mant6_reg >> (fmt_mant_bits(fmt6_reg) - 6'd1)) == MANT_W'(1)))
        else $error("normal result not normalized");

    // a full stage that cannot move keeps its valid
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && !r5) |=> v5_reg)
        else $error("stalled stage dropped its item");

endmodule
